### hdl/sobel_pkg.sv
package sobel_pkg;

   // Field and register widths.
   localparam int COLOR_W = 8;
   localparam int SUM_W = 10;
   localparam int GRAY_W = 8;
   localparam int MAG_W = 11;
   localparam int ROW_W = 12;
   localparam int COL_W = 10;
   localparam int WIDTH_REG_W = 11;
   localparam int HEIGHT_REG_W = 13;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W = 13;

   // Common width for comparing counters against the frame size.
   localparam int DIM_W = 13;

   localparam int DEFAULT_MAX_WIDTH = 1024;
   localparam int MAX_HEIGHT = 4096;
   localparam int MIN_DIM = 3;
   localparam logic [WIDTH_REG_W-1:0] RESET_WIDTH = WIDTH_REG_W'(640);
   localparam logic [HEIGHT_REG_W-1:0] RESET_HEIGHT = HEIGHT_REG_W'(480);

   // Gray = sum / 3 done as (sum * 683) >> 11, exact for sums up to 765.
   localparam int GRAY_RECIP = 683;
   localparam int GRAY_SHIFT = 11;
   localparam int PROD_W = 20;

   // Gradient and root widths.
   localparam int GRAD_W = 10;
   localparam int SQ_W = 20;
   localparam int SUMSQ_W = 21;
   localparam int ROOT_W = 22;
   localparam int MAX_MAGNITUDE = 1443;

   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = CSR_INDEX_W'(1);

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_READ = 7'b0000010,
      ST_GRAD = 7'b0000100,
      ST_SQR  = 7'b0001000,
      ST_SUM  = 7'b0010000,
      ST_ROOT = 7'b0100000,
      ST_FIN  = 7'b1000000
   } state_type;

endpackage

### hdl/sobel_edge_magnitude.sv
// Channel   Direction  Handshake                Payload
// req       in         req_valid / req_ready    req_red, req_green, req_blue
// rsp       out        rsp_valid / rsp_ready    rsp_edge_magnitude, rsp_center_row,
//                                               rsp_center_col, rsp_frame_last
// csr       in         csr_valid / csr_ready    csr_index, csr_data
//
// A border pixel passes through accept with line store read, then write back.
// An interior pixel passes through accept, read, gradient, squares, sum, an 11-step
// root loop at one root bit per cycle, and the output step.
// Reset is synchronous; it clears counters, window and control, not the line store.
// A waiting result stalls only the output step of the next interior pixel; a csr
// beat takes priority over a pixel offered in the same cycle.
module sobel_edge_magnitude #(
   parameter int MAX_WIDTH = sobel_pkg::DEFAULT_MAX_WIDTH
) (
   input  logic clock,
   input  logic reset,

   input  logic req_valid,
   output logic req_ready,
   input  logic [sobel_pkg::COLOR_W-1:0] req_red,
   input  logic [sobel_pkg::COLOR_W-1:0] req_green,
   input  logic [sobel_pkg::COLOR_W-1:0] req_blue,

   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [sobel_pkg::MAG_W-1:0] rsp_edge_magnitude,
   output logic [sobel_pkg::ROW_W-1:0] rsp_center_row,
   output logic [sobel_pkg::COL_W-1:0] rsp_center_col,
   output logic rsp_frame_last,

   input  logic csr_valid,
   output logic csr_ready,
   input  logic [sobel_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [sobel_pkg::CSR_DATA_W-1:0] csr_data
);

   localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int DW = sobel_pkg::DIM_W;
   localparam int GW = sobel_pkg::GRAY_W;
   localparam logic [DW-1:0] MAX_W_C = DW'(MAX_WIDTH);
   localparam logic [DW-1:0] MAX_H_C = DW'(sobel_pkg::MAX_HEIGHT);
   localparam logic [DW-1:0] MIN_C = DW'(sobel_pkg::MIN_DIM);

   sobel_pkg::state_type state_ff, state_in;

   logic [sobel_pkg::WIDTH_REG_W-1:0] width_ff;
   logic [sobel_pkg::HEIGHT_REG_W-1:0] height_ff;
   logic [CW-1:0] col_ff;
   logic [sobel_pkg::ROW_W-1:0] row_ff;

   // Line store: upper byte is two rows back, lower byte is one row back.
   logic [2*GW-1:0] line_mem [MAX_WIDTH];
   logic [2*GW-1:0] rd_ff;
   logic [CW-1:0] addr_ff;

   logic [GW-1:0] win_ff [9];
   logic [sobel_pkg::SUM_W-1:0] sum_ff;
   logic emit_ff;
   logic last_ff;
   logic [sobel_pkg::ROW_W-1:0] cen_row_ff;

   logic [sobel_pkg::GRAD_W-1:0] ax_ff, ay_ff;
   logic [sobel_pkg::SQ_W-1:0] sqx_ff, sqy_ff;
   logic [sobel_pkg::ROOT_W-1:0] rem_ff, root_ff;
   logic [sobel_pkg::ROOT_W-1:0] bit_ff;

   logic rsp_valid_ff;
   logic [sobel_pkg::MAG_W-1:0] mag_ff;
   logic [sobel_pkg::ROW_W-1:0] out_row_ff;
   logic [sobel_pkg::COL_W-1:0] out_col_ff;
   logic out_last_ff;

   logic [DW-1:0] width_ext, height_ext, eff_w, eff_h, col_ext, row_ext;
   logic col_end, row_end;
   logic req_fire, csr_fire, rsp_free;
   logic [sobel_pkg::PROD_W-1:0] gray_prod;
   logic [GW-1:0] gray;
   logic [sobel_pkg::GRAD_W-1:0] xpos, xneg, ypos, yneg;
   logic [sobel_pkg::ROOT_W-1:0] trial;
   logic [sobel_pkg::ROOT_W-1:0] root_rounded;

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == sobel_pkg::ST_IDLE) & ~csr_valid;
   assign req_fire = req_valid & req_ready;
   assign csr_fire = csr_valid & csr_ready;
   assign rsp_free = ~rsp_valid_ff | rsp_ready;

   // Frame size clamped to the legal range.
   always_comb begin
      width_ext = DW'(width_ff);
      height_ext = DW'(height_ff);
      if (width_ext < MIN_C) begin
         eff_w = MIN_C;
      end else if (width_ext > MAX_W_C) begin
         eff_w = MAX_W_C;
      end else begin
         eff_w = width_ext;
      end
      if (height_ext < MIN_C) begin
         eff_h = MIN_C;
      end else if (height_ext > MAX_H_C) begin
         eff_h = MAX_H_C;
      end else begin
         eff_h = height_ext;
      end
      col_ext = DW'(col_ff);
      row_ext = DW'(row_ff);
      col_end = (col_ext == eff_w - DW'(1));
      row_end = (row_ext == eff_h - DW'(1));
   end

   assign gray_prod = sobel_pkg::PROD_W'(sum_ff) * sobel_pkg::PROD_W'(sobel_pkg::GRAY_RECIP);
   assign gray = GW'(gray_prod >> sobel_pkg::GRAY_SHIFT);

   // Kernel taps split into positive and negative halves, so no sign is carried.
   assign xpos = sobel_pkg::GRAD_W'(win_ff[0]) + {1'b0, win_ff[3], 1'b0}
               + sobel_pkg::GRAD_W'(win_ff[6]);
   assign xneg = sobel_pkg::GRAD_W'(win_ff[2]) + {1'b0, win_ff[5], 1'b0}
               + sobel_pkg::GRAD_W'(win_ff[8]);
   assign ypos = sobel_pkg::GRAD_W'(win_ff[0]) + {1'b0, win_ff[1], 1'b0}
               + sobel_pkg::GRAD_W'(win_ff[2]);
   assign yneg = sobel_pkg::GRAD_W'(win_ff[6]) + {1'b0, win_ff[7], 1'b0}
               + sobel_pkg::GRAD_W'(win_ff[8]);

   assign trial = root_ff + bit_ff;
   assign root_rounded = (rem_ff > root_ff) ? root_ff + sobel_pkg::ROOT_W'(1) : root_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sobel_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = sobel_pkg::ST_READ;
            end
         end
         sobel_pkg::ST_READ: begin
            state_in = emit_ff ? sobel_pkg::ST_GRAD : sobel_pkg::ST_IDLE;
         end
         sobel_pkg::ST_GRAD: state_in = sobel_pkg::ST_SQR;
         sobel_pkg::ST_SQR:  state_in = sobel_pkg::ST_SUM;
         sobel_pkg::ST_SUM:  state_in = sobel_pkg::ST_ROOT;
         sobel_pkg::ST_ROOT: begin
            if (bit_ff[0]) begin
               state_in = sobel_pkg::ST_FIN;
            end
         end
         sobel_pkg::ST_FIN: begin
            if (rsp_free) begin
               state_in = sobel_pkg::ST_IDLE;
            end
         end
         default: state_in = sobel_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sobel_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Configuration and raster counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= sobel_pkg::RESET_WIDTH;
         height_ff <= sobel_pkg::RESET_HEIGHT;
         col_ff <= '0;
         row_ff <= '0;
      end else if (csr_fire) begin
         unique case (csr_index)
            sobel_pkg::CSR_IMAGE_WIDTH: begin
               width_ff <= csr_data[sobel_pkg::WIDTH_REG_W-1:0];
               col_ff <= '0;
               row_ff <= '0;
            end
            sobel_pkg::CSR_IMAGE_HEIGHT: begin
               height_ff <= csr_data[sobel_pkg::HEIGHT_REG_W-1:0];
               col_ff <= '0;
               row_ff <= '0;
            end
            default: begin
            end
         endcase
      end else if (req_fire) begin
         if (col_end) begin
            col_ff <= '0;
            row_ff <= row_end ? '0 : row_ff + sobel_pkg::ROW_W'(1);
         end else begin
            col_ff <= col_ff + CW'(1);
         end
      end
   end

   // Per-pixel context captured at accept time.
   always_ff @(posedge clock) begin
      if (reset) begin
         emit_ff <= 1'b0;
      end else if (req_fire) begin
         emit_ff <= (row_ff >= sobel_pkg::ROW_W'(2)) && (col_ff >= CW'(2));
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         addr_ff <= col_ff;
         sum_ff <= sobel_pkg::SUM_W'(req_red) + sobel_pkg::SUM_W'(req_green)
                 + sobel_pkg::SUM_W'(req_blue);
         last_ff <= row_end && col_end;
         cen_row_ff <= row_ff - sobel_pkg::ROW_W'(1);
      end
   end

   // Line store: read at accept, write back in the next cycle. Only one pixel is
   // in flight, so a read never sees a pending write to the same column.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rd_ff <= line_mem[col_ff];
      end
      if (state_ff == sobel_pkg::ST_READ) begin
         line_mem[addr_ff] <= {rd_ff[GW-1:0], gray};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= '0;
         end
      end else if (state_ff == sobel_pkg::ST_READ) begin
         win_ff[0] <= win_ff[1];
         win_ff[1] <= win_ff[2];
         win_ff[2] <= rd_ff[2*GW-1:GW];
         win_ff[3] <= win_ff[4];
         win_ff[4] <= win_ff[5];
         win_ff[5] <= rd_ff[GW-1:0];
         win_ff[6] <= win_ff[7];
         win_ff[7] <= win_ff[8];
         win_ff[8] <= gray;
      end
   end

   // Gradient, squares and the restoring square root.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         sobel_pkg::ST_GRAD: begin
            ax_ff <= (xpos >= xneg) ? xpos - xneg : xneg - xpos;
            ay_ff <= (ypos >= yneg) ? ypos - yneg : yneg - ypos;
         end
         sobel_pkg::ST_SQR: begin
            sqx_ff <= sobel_pkg::SQ_W'(ax_ff) * sobel_pkg::SQ_W'(ax_ff);
            sqy_ff <= sobel_pkg::SQ_W'(ay_ff) * sobel_pkg::SQ_W'(ay_ff);
         end
         sobel_pkg::ST_SUM: begin
            rem_ff <= sobel_pkg::ROOT_W'(sqx_ff) + sobel_pkg::ROOT_W'(sqy_ff);
            root_ff <= '0;
            bit_ff <= sobel_pkg::ROOT_W'(1) << (sobel_pkg::SUMSQ_W - 1);
         end
         sobel_pkg::ST_ROOT: begin
            if (rem_ff >= trial) begin
               rem_ff <= rem_ff - trial;
               root_ff <= (root_ff >> 1) + bit_ff;
            end else begin
               root_ff <= root_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         default: begin
         end
      endcase
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == sobel_pkg::ST_FIN && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == sobel_pkg::ST_FIN && rsp_free) begin
         mag_ff <= sobel_pkg::MAG_W'(root_rounded);
         out_row_ff <= cen_row_ff;
         out_col_ff <= sobel_pkg::COL_W'(addr_ff - CW'(1));
         out_last_ff <= last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_edge_magnitude = mag_ff;
   assign rsp_center_row = out_row_ff;
   assign rsp_center_col = out_col_ff;
   assign rsp_frame_last = out_last_ff;

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == sobel_pkg::ST_FIN))
      else $error("result appeared without a finished root");

   a_root_remainder: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sobel_pkg::ST_FIN) |-> (rem_ff <= (root_ff << 1)))
      else $error("square root remainder out of range");

   a_mag_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (mag_ff <= sobel_pkg::MAG_W'(sobel_pkg::MAX_MAGNITUDE)
                        && out_row_ff != '0))
      else $error("result magnitude or row out of range");

   a_csr_restart: assert property (@(posedge clock) disable iff (reset)
      (csr_fire && (csr_index == sobel_pkg::CSR_IMAGE_WIDTH
                    || csr_index == sobel_pkg::CSR_IMAGE_HEIGHT))
      |=> (col_ff == '0 && row_ff == '0))
      else $error("frame did not restart after a register write");

endmodule

### sim/sobel_edge_magnitude_tb.sv
`timescale 1ns / 1ps

module sobel_edge_magnitude_tb;

   localparam int SETTLE_CYCLES = 40;
   localparam int RANDOM_ITEMS = 670;
   localparam int unsigned CYCLE_LIMIT = 1_200_000;

   typedef struct packed {
      logic [sobel_pkg::COLOR_W-1:0] red;
      logic [sobel_pkg::COLOR_W-1:0] green;
      logic [sobel_pkg::COLOR_W-1:0] blue;
   } pixel_type;

   typedef struct packed {
      logic [sobel_pkg::MAG_W-1:0] magnitude;
      logic [sobel_pkg::ROW_W-1:0] row;
      logic [sobel_pkg::COL_W-1:0] col;
      logic last;
   } edge_result_type;

   typedef enum int {
      STYLE_NOISE,
      STYLE_SATURATED,
      STYLE_SMOOTH,
      STYLE_BINARY
   } pixel_style_type;

   logic clock;
   logic reset = 1'b1;

   logic req_valid = 1'b0;
   logic req_ready;
   logic [sobel_pkg::COLOR_W-1:0] req_red = '0;
   logic [sobel_pkg::COLOR_W-1:0] req_green = '0;
   logic [sobel_pkg::COLOR_W-1:0] req_blue = '0;

   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [sobel_pkg::MAG_W-1:0] rsp_edge_magnitude;
   logic [sobel_pkg::ROW_W-1:0] rsp_center_row;
   logic [sobel_pkg::COL_W-1:0] rsp_center_col;
   logic rsp_frame_last;

   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [sobel_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [sobel_pkg::CSR_DATA_W-1:0] csr_data = '0;

   sobel_edge_magnitude dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_red(req_red),
      .req_green(req_green),
      .req_blue(req_blue),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_edge_magnitude(rsp_edge_magnitude),
      .rsp_center_row(rsp_center_row),
      .rsp_center_col(rsp_center_col),
      .rsp_frame_last(rsp_frame_last),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // Predictor state: registers, line stores, window and raster position.
   logic [sobel_pkg::WIDTH_REG_W-1:0] width_reg = sobel_pkg::RESET_WIDTH;
   logic [sobel_pkg::HEIGHT_REG_W-1:0] height_reg = sobel_pkg::RESET_HEIGHT;
   logic [sobel_pkg::GRAY_W-1:0] older_line [sobel_pkg::DEFAULT_MAX_WIDTH] = '{default: '0};
   logic [sobel_pkg::GRAY_W-1:0] newer_line [sobel_pkg::DEFAULT_MAX_WIDTH] = '{default: '0};
   int window_px [9] = '{default: 0};
   int col_count = 0;
   int row_count = 0;

   pixel_type pending_pixels [$];
   edge_result_type expected_edges [$];

   int error_count = 0;
   int unsigned cycle_count = 0;
   int idle_pct = 10;
   int gap_left = 0;
   int stall_left = 0;
   int drift_level = 128;
   bit req_beat = 1'b0;
   bit csr_beat = 1'b0;
   pixel_type next_px;
   edge_result_type want;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int clamp_int(input int value, input int lo, input int hi);
      if (value < lo) return lo;
      if (value > hi) return hi;
      return value;
   endfunction

   // Floor root by bisection, then round up when s is past root*root + root.
   function automatic int nearest_root(input int s);
      int lo;
      int hi;
      int mid;
      lo = 0;
      hi = 2048;
      while (hi - lo > 1) begin
         mid = (lo + hi) / 2;
         if (mid * mid <= s) lo = mid;
         else hi = mid;
      end
      if (s - lo * lo > lo) lo++;
      return lo;
   endfunction

   task automatic report_mismatch(input string what);
      error_count++;
      $display("MISMATCH cycle %0d: %s", cycle_count, what);
   endtask

   task automatic add_pixel(input pixel_type px);
      pending_pixels = {pending_pixels, px};
   endtask

   task automatic predict_edge(input pixel_type px);
      int w;
      int h;
      int col;
      int row;
      int gx;
      int gy;
      int k;
      edge_result_type res;
      w = clamp_int(int'(width_reg), sobel_pkg::MIN_DIM, sobel_pkg::DEFAULT_MAX_WIDTH);
      h = clamp_int(int'(height_reg), sobel_pkg::MIN_DIM, sobel_pkg::MAX_HEIGHT);
      col = (col_count >= w) ? 0 : col_count;
      row = (row_count >= h) ? 0 : row_count;
      for (k = 0; k < 3; k++) begin
         window_px[3*k] = window_px[3*k+1];
         window_px[3*k+1] = window_px[3*k+2];
      end
      window_px[2] = int'(older_line[col]);
      window_px[5] = int'(newer_line[col]);
      window_px[8] = (int'(px.red) + int'(px.green) + int'(px.blue)) / 3;
      older_line[col] = newer_line[col];
      newer_line[col] = sobel_pkg::GRAY_W'(window_px[8]);
      // The window is complete once two rows, and two columns of this row, have already passed.
      if (row >= 2 && col >= 2) begin
         gx = window_px[0] + 2 * window_px[3] + window_px[6]
            - window_px[2] - 2 * window_px[5] - window_px[8];
         gy = window_px[0] + 2 * window_px[1] + window_px[2]
            - window_px[6] - 2 * window_px[7] - window_px[8];
         res.magnitude = sobel_pkg::MAG_W'(nearest_root(gx * gx + gy * gy));
         res.row = sobel_pkg::ROW_W'(row - 1);
         res.col = sobel_pkg::COL_W'(col - 1);
         res.last = (row == h - 1) && (col == w - 1);
         expected_edges = {expected_edges, res};
      end
      if (col + 1 >= w) begin
         col_count = 0;
         row_count = (row + 1 >= h) ? 0 : row + 1;
      end else begin
         col_count = col + 1;
         row_count = row;
      end
   endtask

   task automatic queue_pixels(input int count, input pixel_style_type style);
      pixel_type px;
      int k;
      for (k = 0; k < count; k++) begin
         case (style)
            STYLE_SATURATED: begin
               px.red = $urandom_range(0, 1) ? 8'hFF : 8'h00;
               px.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
               px.blue = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
            STYLE_SMOOTH: begin
               drift_level = clamp_int(drift_level + $urandom_range(0, 8) - 4, 0, 255);
               px.red = sobel_pkg::COLOR_W'(drift_level);
               px.green = sobel_pkg::COLOR_W'(
                  clamp_int(drift_level + $urandom_range(0, 4) - 2, 0, 255));
               px.blue = sobel_pkg::COLOR_W'(drift_level);
            end
            STYLE_BINARY: begin
               px = $urandom_range(0, 1) ? '1 : '0;
            end
            default: begin
               px = pixel_type'(24'($urandom));
            end
         endcase
         add_pixel(px);
      end
   endtask

   // Returns on a falling edge once every pixel is in and every edge result out.
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_pixels.size() != 0 || req_valid || expected_edges.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Called on a falling edge; returns on a falling edge.
   task automatic write_reg(input logic [sobel_pkg::CSR_INDEX_W-1:0] index,
                            input logic [sobel_pkg::CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(negedge clock);
      while (!csr_beat);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Pixel driver.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_beat) begin
         if (req_beat && $urandom_range(0, 99) < idle_pct)
            gap_left = $urandom_range(1, 18);
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_pixels.size() != 0) begin
            next_px = pending_pixels.pop_front();
            req_valid <= 1'b1;
            req_red <= next_px.red;
            req_green <= next_px.green;
            req_blue <= next_px.blue;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result back-pressure.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 99) < idle_pct / 2) begin
         stall_left = $urandom_range(0, 17);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Monitor: checks result beats, then feeds accepted pixel and register beats
   // to the predictor.
   always @(posedge clock) begin
      cycle_count++;
      if (reset) begin
         req_beat = 1'b0;
         csr_beat = 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_edges.size() == 0) begin
               report_mismatch($sformatf("edge result at row %0d col %0d with none pending",
                                         rsp_center_row, rsp_center_col));
            end else begin
               want = expected_edges.pop_front();
               if (rsp_edge_magnitude !== want.magnitude)
                  report_mismatch($sformatf("magnitude %0d, expected %0d at row %0d col %0d",
                                            rsp_edge_magnitude, want.magnitude,
                                            want.row, want.col));
               if (rsp_center_row !== want.row)
                  report_mismatch($sformatf("center row %0d, expected %0d",
                                            rsp_center_row, want.row));
               if (rsp_center_col !== want.col)
                  report_mismatch($sformatf("center col %0d, expected %0d",
                                            rsp_center_col, want.col));
               if (rsp_frame_last !== want.last)
                  report_mismatch($sformatf("frame last %b, expected %b at row %0d col %0d",
                                            rsp_frame_last, want.last, want.row, want.col));
            end
         end
         req_beat = req_valid && req_ready;
         if (req_beat)
            predict_edge('{req_red, req_green, req_blue});
         csr_beat = csr_valid && csr_ready;
         if (csr_beat) begin
            // A known register restarts the frame; other indexes change nothing.
            if (csr_index == sobel_pkg::CSR_IMAGE_WIDTH) begin
               width_reg = csr_data[sobel_pkg::WIDTH_REG_W-1:0];
               col_count = 0;
               row_count = 0;
            end else if (csr_index == sobel_pkg::CSR_IMAGE_HEIGHT) begin
               height_reg = csr_data[sobel_pkg::HEIGHT_REG_W-1:0];
               col_count = 0;
               row_count = 0;
            end
         end
      end
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      int random_items;
      int w_val;
      int h_val;
      int cur_w;
      int cur_h;
      int n;
      int split;
      pixel_style_type style;

      random_items = 0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // Frame size straight out of reset: a partial first row, which yields no results.
      queue_pixels(24, STYLE_NOISE);
      wait_drained();

      // Upper data bits fall outside the width register, so this is width 3.
      write_reg(sobel_pkg::CSR_IMAGE_WIDTH, 13'h1803);
      write_reg(sobel_pkg::CSR_IMAGE_HEIGHT, 13'd3);
      // Strong gradient with both components positive; truncated gray values.
      add_pixel('{8'd255, 8'd255, 8'd255});
      add_pixel('{8'd255, 8'd255, 8'd254});
      add_pixel('{8'd255, 8'd255, 8'd255});
      add_pixel('{8'd255, 8'd255, 8'd255});
      add_pixel('{8'd255, 8'd0, 8'd0});
      add_pixel('{8'd0, 8'd0, 8'd0});
      add_pixel('{8'd0, 8'd0, 8'd0});
      add_pixel('{8'd0, 8'd0, 8'd1});
      add_pixel('{8'd0, 8'd0, 8'd0});
      // Mirror image: both components negative and the largest reachable magnitude.
      add_pixel('{8'd0, 8'd0, 8'd0});
      add_pixel('{8'd0, 8'd0, 8'd0});
      add_pixel('{8'd0, 8'd0, 8'd0});
      add_pixel('{8'd0, 8'd0, 8'd0});
      add_pixel('{8'd0, 8'd255, 8'd0});
      add_pixel('{8'd255, 8'd255, 8'd255});
      add_pixel('{8'd255, 8'd255, 8'd255});
      add_pixel('{8'd255, 8'd255, 8'd255});
      add_pixel('{8'd255, 8'd255, 8'd255});
      wait_drained();

      // Widest frame, width clamped down and height clamped up; part of the first row.
      idle_pct = 3;
      write_reg(sobel_pkg::CSR_IMAGE_WIDTH, 13'h1FFF);
      write_reg(sobel_pkg::CSR_IMAGE_HEIGHT, 13'd2);
      queue_pixels(24, STYLE_SMOOTH);
      wait_drained();

      // Tallest frame, run in part; an unknown register mid-frame must not restart it.
      idle_pct = 20;
      write_reg(sobel_pkg::CSR_IMAGE_HEIGHT, 13'h1FFF);
      write_reg(sobel_pkg::CSR_IMAGE_WIDTH, 13'd0);
      queue_pixels(3 * 40, STYLE_NOISE);
      wait_drained();
      write_reg(sobel_pkg::CSR_INDEX_W'(9), 13'h1555);
      queue_pixels(3 * 10, STYLE_SATURATED);
      wait_drained();
      write_reg(sobel_pkg::CSR_IMAGE_HEIGHT, 13'd4096);
      write_reg(sobel_pkg::CSR_IMAGE_WIDTH, 13'd1);
      queue_pixels(3 * 6, STYLE_BINARY);
      wait_drained();

      while (random_items < RANDOM_ITEMS) begin
         idle_pct = $urandom_range(0, 3) * 12;
         case ($urandom_range(0, 9))
            0: w_val = $urandom_range(0, 2);
            1: w_val = $urandom_range(13, 40);
            default: w_val = $urandom_range(3, 12);
         endcase
         case ($urandom_range(0, 9))
            0: h_val = $urandom_range(0, 2);
            1: h_val = $urandom_range(0, 1) ? 8191 : $urandom_range(9, 4096);
            default: h_val = $urandom_range(3, 8);
         endcase
         case ($urandom_range(0, 3))
            0: begin
               write_reg(sobel_pkg::CSR_IMAGE_WIDTH, {2'($urandom), 11'(w_val)});
               write_reg(sobel_pkg::CSR_IMAGE_HEIGHT, 13'(h_val));
            end
            1: begin
               write_reg(sobel_pkg::CSR_IMAGE_HEIGHT, 13'(h_val));
               write_reg(sobel_pkg::CSR_IMAGE_WIDTH, {2'($urandom), 11'(w_val)});
            end
            2: write_reg(sobel_pkg::CSR_IMAGE_WIDTH, {2'($urandom), 11'(w_val)});
            default: write_reg(sobel_pkg::CSR_IMAGE_HEIGHT, 13'(h_val));
         endcase
         if ($urandom_range(0, 4) == 0)
            write_reg(sobel_pkg::CSR_INDEX_W'($urandom_range(2, 15)),
                      sobel_pkg::CSR_DATA_W'($urandom));

         cur_w = clamp_int(int'(width_reg), sobel_pkg::MIN_DIM, sobel_pkg::DEFAULT_MAX_WIDTH);
         cur_h = clamp_int(int'(height_reg), sobel_pkg::MIN_DIM, sobel_pkg::MAX_HEIGHT);
         if (cur_h <= 8) n = $urandom_range(1, 2) * cur_w * cur_h;
         else n = cur_w * $urandom_range(3, 7);
         if (n > RANDOM_ITEMS - random_items) n = RANDOM_ITEMS - random_items;
         style = pixel_style_type'($urandom_range(0, 3));

         // Sometimes hold the pixels back mid-frame until every result is out.
         if (n > 1 && $urandom_range(0, 3) == 0) begin
            split = $urandom_range(1, n - 1);
            queue_pixels(split, style);
            wait_drained();
            if ($urandom_range(0, 1) == 0)
               write_reg(sobel_pkg::CSR_INDEX_W'($urandom_range(2, 15)),
                         sobel_pkg::CSR_DATA_W'($urandom));
            queue_pixels(n - split, style);
         end else begin
            queue_pixels(n, style);
         end
         wait_drained();
         random_items += n;
      end

      // Closing stretch at full rate on both sides.
      idle_pct = 0;
      write_reg(sobel_pkg::CSR_IMAGE_WIDTH, 13'd6);
      write_reg(sobel_pkg::CSR_IMAGE_HEIGHT, 13'd4);
      queue_pixels(2 * 6 * 4, STYLE_NOISE);
      wait_drained();

      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
